[rtl/countdown_timer_pool_unit_macros.svh]
// ----------------------------------------------------------------------------
// Countdown timer pool assertion macros
// Shared concurrent-assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_POOL_UNIT_MACROS_SVH
`define COUNTDOWN_TIMER_POOL_UNIT_MACROS_SVH

// Checked outside reset only.
`define CTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ctp_pkg.sv]
// ----------------------------------------------------------------------------
// Countdown timer pool package
// Widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 16;
  localparam int MAX_SLOTS  = 16;
  localparam int DEF_TIMER_SLOTS = 3;

  localparam logic [COUNT_W-1:0] COUNT_ABSENT = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

  // Controller -> datapath
  typedef struct packed {
    logic latch;  // capture the request fields
    logic exec;   // apply the latched request
  } ctp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic has_result;  // latched request produces a result
  } ctp_stat_t;

endpackage

[rtl/ctp_datapath.sv]
// ----------------------------------------------------------------------------
// Countdown timer pool datapath
// Request latch, slot register bank, first-free encoder and result registers.
// ----------------------------------------------------------------------------
module ctp_datapath import ctp_pkg::*; #(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctp_cmd_t           cmd,
  output ctp_stat_t          stat,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [COUNT_W-1:0] in_load_value,
  output logic               out_ok,
  output logic [SLOT_W-1:0]  out_slot_index,
  output logic [COUNT_W-1:0] out_count
);

  logic [KIND_W-1:0]      kind_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [COUNT_W-1:0]     load_r;

  logic [TIMER_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [COUNT_W-1:0]     count_r   [TIMER_SLOTS];
  logic [COUNT_W-1:0]     count_nxt [TIMER_SLOTS];

  logic                   ok_r, ok_nxt;
  logic [SLOT_W-1:0]      sidx_r, sidx_nxt;
  logic [COUNT_W-1:0]     cnt_r, cnt_nxt;

  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic                   rd_hit;
  logic [COUNT_W-1:0]     rd_cnt;

  assign stat.has_result = (kind_r == KIND_ALLOC) || (kind_r == KIND_READ);

  // lowest free slot wins: scan from the top down
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // read select; slots past the pool never match
  always_comb begin
    rd_hit = 1'b0;
    rd_cnt = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (slot_r == SLOT_W'(i)) begin
        rd_hit = in_use_r[i];
        rd_cnt = count_r[i];
      end
    end
  end

  always_comb begin
    in_use_nxt = in_use_r;
    for (int i = 0; i < TIMER_SLOTS; i++) count_nxt[i] = count_r[i];
    ok_nxt   = ok_r;
    sidx_nxt = sidx_r;
    cnt_nxt  = cnt_r;
    if (cmd.exec) begin
      unique case (kind_r)
        KIND_TICK: begin
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (in_use_r[i] && (count_r[i] != '0)) count_nxt[i] = count_r[i] - 1'b1;
          end
        end
        KIND_ALLOC: begin
          ok_nxt   = free_found;
          sidx_nxt = free_found ? free_idx : '0;
          cnt_nxt  = free_found ? load_r : '0;
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (free_found && (free_idx == SLOT_W'(i))) begin
              in_use_nxt[i] = 1'b1;
              count_nxt[i]  = load_r;
            end
          end
        end
        KIND_READ: begin
          ok_nxt   = rd_hit;
          sidx_nxt = slot_r;
          cnt_nxt  = rd_hit ? rd_cnt : COUNT_ABSENT;
        end
        KIND_RELEASE: begin
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (slot_r == SLOT_W'(i)) begin
              in_use_nxt[i] = 1'b0;
              count_nxt[i]  = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      for (int i = 0; i < TIMER_SLOTS; i++) count_r[i] <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      for (int i = 0; i < TIMER_SLOTS; i++) count_r[i] <= count_nxt[i];
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      slot_r <= in_slot;
      load_r <= in_load_value;
    end
    ok_r   <= ok_nxt;
    sidx_r <= sidx_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_ok         = ok_r;
  assign out_slot_index = sidx_r;
  assign out_count      = cnt_r;

endmodule

[rtl/ctp_ctrl.sv]
// ----------------------------------------------------------------------------
// Countdown timer pool controller
// Two-state sequencer: take a request, execute it, strobe the result.
// ----------------------------------------------------------------------------
module ctp_ctrl import ctp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output ctp_cmd_t  cmd,
  input  ctp_stat_t stat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic valid_r, valid_nxt;

  assign busy      = (state_r == ST_EXEC);
  assign cmd.latch = (state_r == ST_IDLE) && start;
  assign cmd.exec  = (state_r == ST_EXEC);

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        valid_nxt = stat.has_result;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule

[rtl/countdown_timer_pool_unit.sv]
// ----------------------------------------------------------------------------
// Countdown timer pool unit
// Pool of TIMER_SLOTS 16-bit countdown timers with tick/allocate/read/release.
// ----------------------------------------------------------------------------
// A request (in_kind, in_slot, in_load_value) is taken at a clock edge with
// start high and busy low. Each request is captured at that edge and then
// applied to the slot register bank while busy is high, so busy is high for
// exactly one cycle after each accept and no request is taken in that cycle.
// Allocate and read produce one result, shown on out_* for a single cycle
// with out_valid high, in the cycle right after execution; the receiver
// cannot stall it, so it must take the result in that cycle. That cycle
// overlaps the next possible accept. Tick and release produce no result.
// Tick decrements every in-use slot above zero (stops at zero). Allocate
// grants the lowest free slot (ok=0, slot 0, count 0 when the pool is full).
// Read of a free or out-of-range slot returns ok=0 and count 0xFFFF.
// Release of an out-of-range slot does nothing. No clearing pass after reset.
// ----------------------------------------------------------------------------
module countdown_timer_pool_unit import ctp_pkg::*; #(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS  // 1 .. MAX_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [COUNT_W-1:0] in_load_value,
  output logic               out_valid,
  output logic               out_ok,
  output logic [SLOT_W-1:0]  out_slot_index,
  output logic [COUNT_W-1:0] out_count
);

  ctp_cmd_t  cmd;
  ctp_stat_t stat;

  // sequencer: accept, execute, result strobe
  ctp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // slot bank plus result registers
  ctp_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_slot        (in_slot),
    .in_load_value  (in_load_value),
    .out_ok         (out_ok),
    .out_slot_index (out_slot_index),
    .out_count      (out_count)
  );

endmodule

[rtl/ctp_checker.sv]
// ----------------------------------------------------------------------------
// Countdown timer pool checker
// Port-level checks on request/result timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "countdown_timer_pool_unit_macros.svh"

module ctp_checker import ctp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_ok,
  input logic [SLOT_W-1:0]  out_slot_index,
  input logic [COUNT_W-1:0] out_count
);

  `CTP_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")
  `CTP_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy missing after accept")
  `CTP_ASSERT(a_result_after_exec, out_valid |-> $past(busy), "result without execution")
  `CTP_ASSERT(a_single_strobe, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `CTP_ASSERT(a_alloc_fail, (out_valid && !out_ok && (out_count != COUNT_ABSENT)) |->
    ((out_slot_index == '0) && (out_count == '0)), "bad failed-allocate result")

endmodule

bind countdown_timer_pool_unit ctp_checker u_ctp_checker (.*);

[sim/tb_countdown_timer_pool_unit.sv]
// ----------------------------------------------------------------------------
// Countdown timer pool unit testbench
// Drives tick, allocate, read and release requests into the timer pool. A
// scoreboard keeps its own copy of the slot bank, predicts each answer and
// checks every out_valid strobe against the oldest outstanding answer.
// Directed corner cases come first, then three random phases with
// different sender idle rates.
// ----------------------------------------------------------------------------
module tb_countdown_timer_pool_unit;
  import ctp_pkg::*;

  localparam int SLOTS       = DEF_TIMER_SLOTS;  // uut uses its default
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 180;

  // One expected answer of an allocate or read request.
  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] count;
  } answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of the slot bank plus a FIFO of answers.
  // --------------------------------------------------------------------------
  class timer_pool_scoreboard;
    bit                 in_use [MAX_SLOTS];
    logic [COUNT_W-1:0] remain [MAX_SLOTS];
    answer_t            pending_answers [$];
    int                 fails;

    function new();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        in_use[i] = 0;
        remain[i] = '0;
      end
      fails = 0;
    endfunction

    // Apply one accepted request to the slot bank; queue its answer if any.
    function void note_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [COUNT_W-1:0] load);
      answer_t a;
      bit      granted;
      granted = 0;
      a = '0;
      case (kind)
        KIND_TICK: begin
          for (int i = 0; i < SLOTS; i++)
            if (in_use[i] && remain[i] != '0) remain[i] = remain[i] - 1'b1;
        end
        KIND_ALLOC: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!granted && !in_use[i]) begin
              granted = 1;
              in_use[i] = 1;
              remain[i] = load;
              a.ok = 1'b1;
              a.slot_index = SLOT_W'(i);
              a.count = load;
            end
          end
          pending_answers.push_back(a);  // pool full: all zero
        end
        KIND_READ: begin
          a.slot_index = slot;
          if (slot < SLOTS && in_use[slot]) begin
            a.ok = 1'b1;
            a.count = remain[slot];
          end else begin
            a.count = COUNT_ABSENT;
          end
          pending_answers.push_back(a);
        end
        default: begin  // release; out of range is ignored
          if (slot < SLOTS) begin
            in_use[slot] = 0;
            remain[slot] = '0;
          end
        end
      endcase
    endfunction

    function void check_answer(logic ok, logic [SLOT_W-1:0] idx, logic [COUNT_W-1:0] cnt);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer ok=%0d slot=%0d count=%0h", $time, ok, idx, cnt);
        fails++;
        return;
      end
      a = pending_answers.pop_front();
      if (ok !== a.ok) begin
        $display("%0t: ok mismatch, expected %0d, got %0d", $time, a.ok, ok);
        fails++;
      end
      if (idx !== a.slot_index) begin
        $display("%0t: slot_index mismatch, expected %0d, got %0d", $time, a.slot_index, idx);
        fails++;
      end
      if (cnt !== a.count) begin
        $display("%0t: count mismatch, expected %0h, got %0h", $time, a.count, cnt);
        fails++;
      end
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [KIND_W-1:0]  in_kind;
  logic [SLOT_W-1:0]  in_slot;
  logic [COUNT_W-1:0] in_load_value;
  logic               out_valid;
  logic               out_ok;
  logic [SLOT_W-1:0]  out_slot_index;
  logic [COUNT_W-1:0] out_count;

  countdown_timer_pool_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_slot        (in_slot),
    .in_load_value  (in_load_value),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_slot_index (out_slot_index),
    .out_count      (out_count)
  );

  timer_pool_scoreboard sb;
  int                   cycle_count;
  int                   idle_pct;  // sender idle chance per cycle, percent

  // 2 time unit clock period
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the flops of
  // the uut update. The answer check runs ahead of noting a new request so
  // the oldest answer is always at the queue head.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_answer(out_ok, out_slot_index, out_count);
      if (start && !busy) sb.note_request(in_kind, in_slot, in_load_value);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_countdown_timer_pool_unit: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All are entered and left at a falling edge; start stays
  // high across back-to-back requests and is only lowered by idle_cycles.
  // --------------------------------------------------------------------------
  task automatic idle_cycles(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Present one request and hold it until the uut takes it.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                              logic [COUNT_W-1:0] load);
    bit taken;
    // each cycle the sender could offer, it stays idle at idle_pct percent
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      idle_cycles(1);
    start = 1'b1;
    in_kind = kind;
    in_slot = slot;
    in_load_value = load;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  // Hold off until every answer has come back.
  task automatic drain_answers();
    idle_cycles(1);
    while (sb.outstanding() != 0) @(negedge clk);
    idle_cycles(3);  // let the last request finish its execute cycle
  endtask

  // Random request, weighted toward operations that keep the small pool busy.
  task automatic send_random_request();
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] load;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      kind = KIND_ALLOC;
    else if (pick < 57) kind = KIND_READ;
    else if (pick < 80) kind = KIND_TICK;
    else                kind = KIND_RELEASE;
    // mostly 0 to SLOTS (one past the pool), sometimes anywhere in the 4-bit field
    if ($urandom_range(0, 99) < 80) slot = SLOT_W'($urandom_range(0, SLOTS));
    else                            slot = SLOT_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      load = COUNT_W'($urandom_range(0, 6));  // small, so ticks reach zero
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0:       load = 16'h0000;
        1:       load = 16'hFFFF;
        2:       load = 16'h8000;
        default: load = 16'h7FFF;
      endcase
    end else begin
      load = COUNT_W'($urandom());
    end
    send_request(kind, slot, load);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_TICK;
    in_slot = '0;
    in_load_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty pool, extremes of load and slot, full pool, zero count
    send_request(KIND_READ,    4'd0,  16'h1234);  // free slot reads absent
    send_request(KIND_RELEASE, 4'd15, 16'h0000);  // out of range, ignored
    send_request(KIND_TICK,    4'd0,  16'h0000);  // tick on empty pool
    send_request(KIND_ALLOC,   4'd0,  16'hFFFF);
    send_request(KIND_ALLOC,   4'd15, 16'h0000);
    send_request(KIND_ALLOC,   4'd0,  16'h0001);
    send_request(KIND_ALLOC,   4'd0,  16'hAAAA);  // pool full
    send_request(KIND_TICK,    4'd0,  16'h0000);
    send_request(KIND_READ,    4'd0,  16'h0000);
    send_request(KIND_READ,    4'd1,  16'h0000);  // stays at zero
    send_request(KIND_READ,    4'd2,  16'h0000);
    send_request(KIND_TICK,    4'd0,  16'h0000);
    send_request(KIND_READ,    4'd2,  16'h0000);  // zero count still in use
    send_request(KIND_READ,    4'd3,  16'h0000);  // just past the pool
    send_request(KIND_READ,    4'd15, 16'hFFFF);
    send_request(KIND_RELEASE, 4'd1,  16'h0000);
    send_request(KIND_READ,    4'd1,  16'h0000);
    send_request(KIND_RELEASE, 4'd1,  16'h0000);  // already free
    send_request(KIND_ALLOC,   4'd0,  16'h5555);  // takes freed slot 1
    send_request(KIND_READ,    4'd1,  16'h0000);
    send_request(KIND_RELEASE, 4'd0,  16'h0000);
    send_request(KIND_RELEASE, 4'd2,  16'h0000);
    send_request(KIND_RELEASE, 4'd1,  16'h0000);
    send_request(KIND_READ,    4'd0,  16'h0000);
    drain_answers();

    // Random phases: busy sender, mostly idle sender, back-to-back
    idle_pct = 31;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_random_request();
      if ($urandom_range(0, 99) < 2) drain_answers();
    end
    drain_answers();

    idle_pct = 84;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
    drain_answers();

    idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();

    // Wait out the last answers, then wait on for any stray strobes.
    idle_cycles(1);
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (6) @(negedge clk);

    if (sb.fails == 0) begin
      $display("tb_countdown_timer_pool_unit: PASS");
    end else begin
      $display("tb_countdown_timer_pool_unit: FAIL");
    end
    $finish;
  end

endmodule
